FILE: rtl/radix_page_table_walker_macros.svh
// Assertion macros shared by the page table walker RTL.
// No dependencies; include with the bare file name.
`ifndef RADIX_PAGE_TABLE_WALKER_MACROS_SVH
`define RADIX_PAGE_TABLE_WALKER_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define RPTW_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that the antecedent implies the consequent in the same cycle.
`define RPTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check that the antecedent implies the consequent in the next cycle.
`define RPTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RPTW_ASSERT(label, clk, rst_n, cond, msg)
`define RPTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RPTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/rptw_pkg.sv
// Package for the radix page table walker: sizes, codes and transaction types.
// No dependencies.
package rptw_pkg;

  localparam int NUM_FRAMES        = 64;
  localparam int LEVELS            = 5;
  localparam int ENTRIES_PER_TABLE = 1024;

  localparam int IDX_BITS = 10;
  localparam int VPN_W    = LEVELS * IDX_BITS;
  localparam int PPN_W    = 51;
  localparam int ENTRY_W  = PPN_W + 1;
  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int ENT_W    = $clog2(ENTRIES_PER_TABLE);
  localparam int ADDR_W   = FRAME_W + ENT_W;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int NFF_W    = FRAME_W + 1;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;

  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MAP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNMAP = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMAP   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFRAME = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [VPN_W-1:0] vpn;
    logic [PPN_W-1:0] ppn;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PPN_W-1:0]  ppn_out;
  } rsp_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [ENTRY_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame;
  } alloc_rsp_t;

endpackage

FILE: rtl/rptw_mem.sv
// Table memory: one write port, one read port with registered read data.
// Depends on rptw_pkg.
module rptw_mem (
  input  logic                     clk,
  input  rptw_pkg::mem_wr_t        wr,
  input  logic                     rd_en,
  input  logic [rptw_pkg::ADDR_W-1:0]  rd_addr,
  output logic [rptw_pkg::ENTRY_W-1:0] rd_data_r
);
  import rptw_pkg::*;

  logic [ENTRY_W-1:0] mem_r [NUM_FRAMES*ENTRIES_PER_TABLE];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

FILE: rtl/rptw_alloc.sv
// In-order frame allocator that passes over the current root frame.
// Depends on rptw_pkg and radix_page_table_walker_macros.svh.
`include "radix_page_table_walker_macros.svh"

module rptw_alloc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rptw_pkg::FRAME_W-1:0] root,
  input  logic                         take,
  output rptw_pkg::alloc_rsp_t         rsp
);
  import rptw_pkg::*;

  logic [NFF_W-1:0] nff_r;
  logic [NFF_W-1:0] nff_nxt;
  logic [NFF_W-1:0] cand;
  logic             skip;

  // Skip the root frame, then see whether a frame is left.
  assign skip      = (nff_r == {1'b0, root});
  assign cand      = nff_r + NFF_W'(skip);
  assign rsp.ok    = (cand < NFF_W'(NUM_FRAMES));
  assign rsp.frame = cand[FRAME_W-1:0];

  // The skip sticks even when the allocation fails.
  assign nff_nxt = rsp.ok ? cand + NFF_W'(1) : cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nff_r <= '0;
    end else if (take) begin
      nff_r <= nff_nxt;
    end
  end

  `RPTW_ASSERT(a_nff_range, clk, rst_n, nff_r <= NFF_W'(NUM_FRAMES), "free pointer out of range")
  `RPTW_ASSERT_IMPLY(a_not_root, clk, rst_n, take && rsp.ok, rsp.frame != root, "root frame handed out")
  `RPTW_ASSERT_NEXT(a_advance, clk, rst_n, take && rsp.ok, nff_r > $past(nff_r), "allocator did not advance")

endmodule

FILE: rtl/radix_page_table_walker.sv
// Top level of the five-level radix page table walker: sequencer, root register.
// Depends on rptw_pkg, rptw_mem, rptw_alloc and radix_page_table_walker_macros.svh.
//
// Usage: after reset the block sweeps the whole table memory to zero, one entry a
// cycle (NUM_FRAMES*ENTRIES_PER_TABLE = 65536 entries), and holds busy high
// meanwhile; root_frame writes on the cfg channel are taken at any time (cfg_ready
// is tied high) but should only be made while busy is low and no result is owed.
// A transaction is taken when start is high and busy is low. The walk visits each
// level by issuing its address, then evaluating the registered read data, since
// each level's address depends on the entry read at the level above and the
// single table memory has one registered read port. The result appears on out_rsp
// with out_valid high for exactly one cycle, and busy falls in that same cycle, so
// a new transaction can be started there; only one transaction is walked at a
// time. The receiver cannot hold results off: capture out_rsp whenever out_valid
// is high. Map creates missing tables from an in-order frame allocator; running
// out of frames reports status 2 and keeps the links made so far.
`include "radix_page_table_walker_macros.svh"

module radix_page_table_walker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rptw_pkg::req_t               in_req,
  output logic                         out_valid,
  output rptw_pkg::rsp_t               out_rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rptw_pkg::FRAME_W-1:0] cfg_data
);
  import rptw_pkg::*;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0]          state_r,     state_nxt;
  logic [LVL_W-1:0]    lvl_r,       lvl_nxt;
  logic [FRAME_W-1:0]  frame_r,     frame_nxt;
  logic [VPN_W-1:0]    vpn_r,       vpn_nxt;
  logic [PPN_W-1:0]    ppn_r,       ppn_nxt;
  logic [REQ_W-1:0]    req_r,       req_nxt;
  logic [ADDR_W-1:0]   clr_addr_r,  clr_addr_nxt;
  logic [FRAME_W-1:0]  root_r;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_rsp_r,   out_rsp_nxt;

  logic [IDX_BITS-1:0] idx_full;
  logic [ADDR_W-1:0]   slot_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic                rd_en;
  logic                is_leaf;
  logic                ent_valid;
  logic [FRAME_W-1:0]  ent_frame;
  logic                take;
  alloc_rsp_t          alloc_rsp;
  mem_wr_t             mem_wr;

  // Index for the current level sits at the top of the shifted VPN; wrap it to
  // the table size by keeping the low bits.
  assign idx_full  = vpn_r[VPN_W-1 -: IDX_BITS];
  assign slot_addr = {frame_r, idx_full[ENT_W-1:0]};
  assign is_leaf   = (lvl_r == LVL_W'(LEVELS - 1));
  assign ent_valid = rd_data[0];
  assign ent_frame = rd_data[FRAME_W:1];
  assign rd_en     = (state_r == S_RD);

  rptw_mem u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_en     (rd_en),
    .rd_addr   (slot_addr),
    .rd_data_r (rd_data)
  );

  rptw_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .root  (root_r),
    .take  (take),
    .rsp   (alloc_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    frame_nxt     = frame_r;
    vpn_nxt       = vpn_r;
    ppn_nxt       = ppn_r;
    req_nxt       = req_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    take          = 1'b0;
    mem_wr.we     = 1'b0;
    mem_wr.addr   = slot_addr;
    mem_wr.data   = '0;

    case (state_r)
      S_CLR: begin
        // Sweep the table to zero after reset.
        mem_wr.we    = 1'b1;
        mem_wr.addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == {ADDR_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req.req_type;
          vpn_nxt   = in_req.vpn;
          ppn_nxt   = in_req.ppn;
          frame_nxt = root_r;
          lvl_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        out_rsp_nxt.status  = ST_OK;
        out_rsp_nxt.ppn_out = '0;
        if (is_leaf) begin
          // Finish at the leaf whatever the request.
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (req_r)
            REQ_MAP: begin
              mem_wr.we   = 1'b1;
              mem_wr.data = {ppn_r, 1'b1};
            end
            REQ_UNMAP: begin
              mem_wr.we   = 1'b1;
              mem_wr.data = {rd_data[ENTRY_W-1:1], 1'b0};
            end
            default: begin
              if (!ent_valid) begin
                out_rsp_nxt.status = ST_NOMAP;
              end else begin
                out_rsp_nxt.ppn_out = rd_data[ENTRY_W-1:1];
              end
            end
          endcase
        end else if (ent_valid) begin
          // Follow the link, wrapping to the frame count.
          frame_nxt = ent_frame;
          lvl_nxt   = lvl_r + LVL_W'(1);
          vpn_nxt   = vpn_r << IDX_BITS;
          state_nxt = S_RD;
        end else if (req_r != REQ_MAP) begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          out_rsp_nxt.status = ST_NOMAP;
        end else begin
          // Missing table on a map: take a frame and link it in, or end with ST_NOFRAME if none is left.
          take = 1'b1;
          if (!alloc_rsp.ok) begin
            state_nxt          = S_IDLE;
            out_valid_nxt      = 1'b1;
            out_rsp_nxt.status = ST_NOFRAME;
          end else begin
            mem_wr.we   = 1'b1;
            mem_wr.data = {{(PPN_W-FRAME_W){1'b0}}, alloc_rsp.frame, 1'b1};
            frame_nxt   = alloc_rsp.frame;
            lvl_nxt     = lvl_r + LVL_W'(1);
            vpn_nxt     = vpn_r << IDX_BITS;
            state_nxt   = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      if (cfg_valid && cfg_ready) begin
        root_r <= cfg_data;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    frame_r   <= frame_nxt;
    vpn_r     <= vpn_nxt;
    ppn_r     <= ppn_nxt;
    req_r     <= req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `RPTW_ASSERT_IMPLY(a_out_idle, clk, rst_n, out_valid_r, state_r == S_IDLE, "result outside idle")
  `RPTW_ASSERT_NEXT(a_start_walk, clk, rst_n, start && !busy, state_r == S_RD, "walk not started")
  `RPTW_ASSERT_IMPLY(a_eval_after_rd, clk, rst_n, state_r == S_EVAL, $past(state_r) == S_RD, "eval without read")
  `RPTW_ASSERT(a_lvl_range, clk, rst_n, lvl_r < LVL_W'(LEVELS), "level counter out of range")

endmodule
